@@ design/lrt_pkg.sv @@
// Shared codes and control structures for the linked row table.
package lrt_pkg;

    // Fixed field widths of the item and configuration ports.
    localparam int FUNC_W = 2;
    localparam int ROW_W  = 10;
    localparam int STEP_W = 10;
    localparam int CNT_W  = 11;

    // Command codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_UP      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DOWN    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESTORE = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_START_ROW = 1'b1;

    // Commands to the undo stack.
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_stk_cmd;

    // Status from the undo stack.
    typedef struct packed {
        logic empty;
        logic full;
    } t_stk_stat;

endpackage

@@ design/lrt_undo_stack.sv @@
// Undo stack of deleted row entries with a registered pop read.
module lrt_undo_stack
    import lrt_pkg::*;
#(
    parameter int MAX_ROWS = 1024,
    parameter int AW       = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_stk_cmd      i_cmd,
    input  logic [AW-1:0] i_push_data,
    output logic [AW-1:0] o_pop_data,
    output t_stk_stat     o_stat
);

    localparam int DW = $clog2(MAX_ROWS + 1);
    localparam int SW = $clog2(MAX_ROWS);

    logic [AW-1:0] r_mem [MAX_ROWS];
    logic [DW-1:0] r_depth;
    logic [AW-1:0] r_pop_data;
    logic [DW-1:0] w_top_full;
    logic [SW-1:0] w_top;

    assign w_top_full = r_depth - DW'(1);
    assign w_top      = w_top_full[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.clear) begin
            r_depth <= '0;
        end else if (i_cmd.push) begin
            r_depth <= r_depth + DW'(1);
        end else if (i_cmd.pop) begin
            r_depth <= w_top_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_depth[SW-1:0]] <= i_push_data;
        end
        if (i_cmd.pop) begin
            r_pop_data <= r_mem[w_top];
        end
    end

    assign o_pop_data   = r_pop_data;
    assign o_stat.empty = (r_depth == '0);
    assign o_stat.full  = (r_depth == DW'(MAX_ROWS));

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_depth != '0)
        else $error("undo stack popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_depth != DW'(MAX_ROWS))
        else $error("undo stack pushed while full");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && i_cmd.pop))
        else $error("undo stack pushed and popped in one cycle");

endmodule

@@ design/linked_row_table_with_undo.sv @@
// Linked row table with cursor, undo stack and per-row presence query.
// A move walks one link per cycle through S_MOVE; a delete passes through S_DEL and a
// restore through S_RST_A and S_RST_B, and every item ends in S_QRY and S_OUT. One item at a
// time: the next is accepted once the block is back in idle after the result is registered,
// and a stalled result holds the block. Synchronous active-low reset, and every row_count
// write, start a clearing pass over every entry up to the tail sentinel that takes no item.
module linked_row_table_with_undo
    import lrt_pkg::*;
#(
    parameter int MAX_ROWS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Item channel.
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [STEP_W-1:0] i_steps,
    input  logic [ROW_W-1:0]  i_query_row,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic              o_row_present,
    output logic              o_error,
    // Configuration write channel.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    // Entry index width covers both sentinels; RW holds a row count.
    localparam int AW         = $clog2(MAX_ROWS + 2);
    localparam int RW         = $clog2(MAX_ROWS + 1);
    localparam int RESET_ROWS = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
    localparam int DEPTH      = MAX_ROWS + 2;

    // Sequencer state codes.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_MOVE  = 4'd3;
    localparam logic [3:0] S_DEL   = 4'd4;
    localparam logic [3:0] S_RST_A = 4'd5;
    localparam logic [3:0] S_RST_B = 4'd6;
    localparam logic [3:0] S_QRY   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // Link and presence memories. Entry 0 is the head sentinel and entry
    // rows+1 the tail sentinel; table row r lives at entry r+1.
    logic [AW-1:0] r_prev_mem [DEPTH];
    logic [AW-1:0] r_next_mem [DEPTH];
    logic          r_pres_mem [DEPTH];

    logic [3:0]        r_state;
    logic [AW-1:0]     r_clr;
    logic [RW-1:0]     r_rows;
    logic [ROW_W-1:0]  r_start;
    logic [AW-1:0]     r_cursor;
    logic [FUNC_W-1:0] r_func;
    logic [STEP_W-1:0] r_steps;
    logic [ROW_W-1:0]  r_query;
    logic [STEP_W-1:0] r_cnt;
    logic              r_err;
    logic              r_qok;
    logic [AW-1:0]     r_rest;
    logic [AW-1:0]     r_prev_rd;
    logic [AW-1:0]     r_next_rd;
    logic              r_pres_rd;
    logic              r_out_valid;
    logic [ROW_W-1:0]  r_out_cursor;
    logic              r_out_present;
    logic              r_out_err;

    logic [AW-1:0] w_tail;
    logic [AW-1:0] w_link;
    logic [AW-1:0] w_stop;
    logic          w_step_go;
    logic [AW-1:0] w_lraddr;
    logic          w_prev_we;
    logic [AW-1:0] w_prev_wa;
    logic [AW-1:0] w_prev_wd;
    logic          w_next_we;
    logic [AW-1:0] w_next_wa;
    logic [AW-1:0] w_next_wd;
    logic          w_pres_we;
    logic [AW-1:0] w_pres_wa;
    logic          w_pres_wd;
    logic [AW-1:0] w_pres_ra;
    logic [31:0]   w_qaddr;
    logic          w_in_acc;
    logic          w_cfg_we;
    logic          w_rows_we;
    logic [31:0]   w_cfg_wide;
    logic [31:0]   w_new_rows;
    logic [31:0]   w_new_start;
    logic [31:0]   w_new_cursor;
    logic [31:0]   w_cur_m1;
    logic [ROW_W-1:0] w_cur_row;
    logic          w_out_free;
    t_stk_cmd      w_stk_cmd;
    t_stk_stat     w_stk_stat;
    logic [AW-1:0] w_stk_data;

    // Items and configuration writes are both taken only from the idle
    // state. A pending configuration write holds off the item channel, so a
    // rebuild never coincides with the start of a command.
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_rows_we   = w_cfg_we && (i_cfg_index == CFG_ROW_COUNT);

    assign w_tail = AW'(r_rows) + AW'(1);

    // Rebuild values: the row count is clamped to 1..MAX_ROWS and the start
    // row to the last row in use.
    assign w_cfg_wide = 32'(i_cfg_data);
    always_comb begin
        if (w_cfg_wide == 32'd0) begin
            w_new_rows = 32'd1;
        end else if (w_cfg_wide > 32'(MAX_ROWS)) begin
            w_new_rows = 32'(MAX_ROWS);
        end else begin
            w_new_rows = w_cfg_wide;
        end
        if (32'(r_start) > w_new_rows - 32'd1) begin
            w_new_start = w_new_rows - 32'd1;
        end else begin
            w_new_start = 32'(r_start);
        end
        w_new_cursor = w_new_start + 32'd1;
    end

    // The shared link walker: one link read and one compare per cycle.
    assign w_link    = (r_func == FUNC_UP) ? r_prev_rd : r_next_rd;
    assign w_stop    = (r_func == FUNC_UP) ? '0 : w_tail;
    assign w_step_go = (r_cnt < r_steps) && (w_link != w_stop);

    // Link read address: normally the cursor entry. While walking, the link
    // just read is fed straight back so that each cycle advances one row.
    // On a restore the entry popped from the stack is read instead.
    always_comb begin
        w_lraddr = r_cursor;
        if (r_state == S_RST_A) begin
            w_lraddr = w_stk_data;
        end else if ((r_state == S_MOVE) && w_step_go) begin
            w_lraddr = w_link;
        end
    end

    // Memory write ports for the clearing pass, unlink and relink.
    always_comb begin
        w_prev_we = 1'b0;
        w_prev_wa = r_clr;
        w_prev_wd = '0;
        w_next_we = 1'b0;
        w_next_wa = r_clr;
        w_next_wd = '0;
        w_pres_we = 1'b0;
        w_pres_wa = r_clr;
        w_pres_wd = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_prev_we = 1'b1;
                w_prev_wd = (r_clr == '0) ? '0 : r_clr - AW'(1);
                w_next_we = 1'b1;
                w_next_wd = (r_clr == w_tail) ? r_clr : r_clr + AW'(1);
                w_pres_we = 1'b1;
                w_pres_wd = 1'b1;
            end
            S_DEL: begin
                w_next_we = 1'b1;
                w_next_wa = r_prev_rd;
                w_next_wd = r_next_rd;
                w_prev_we = 1'b1;
                w_prev_wa = r_next_rd;
                w_prev_wd = r_prev_rd;
                w_pres_we = 1'b1;
                w_pres_wa = r_cursor;
                w_pres_wd = 1'b0;
            end
            S_RST_B: begin
                w_next_we = 1'b1;
                w_next_wa = r_prev_rd;
                w_next_wd = r_rest;
                w_prev_we = 1'b1;
                w_prev_wa = r_next_rd;
                w_prev_wd = r_rest;
                w_pres_we = 1'b1;
                w_pres_wa = r_rest;
                w_pres_wd = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_qaddr   = 32'(r_query) + 32'd1;
    assign w_pres_ra = AW'(w_qaddr);

    always_ff @(posedge i_clk) begin
        if (w_prev_we) begin
            r_prev_mem[w_prev_wa] <= w_prev_wd;
        end
        r_prev_rd <= r_prev_mem[w_lraddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_next_we) begin
            r_next_mem[w_next_wa] <= w_next_wd;
        end
        r_next_rd <= r_next_mem[w_lraddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_pres_we) begin
            r_pres_mem[w_pres_wa] <= w_pres_wd;
        end
        r_pres_rd <= r_pres_mem[w_pres_ra];
    end

    // Undo stack: pushed on a delete, popped when a restore starts, and
    // emptied by a rebuild.
    always_comb begin
        w_stk_cmd.clear = w_rows_we;
        w_stk_cmd.push  = (r_state == S_DEL) && !w_rows_we;
        w_stk_cmd.pop   = (r_state == S_START) && (r_func == FUNC_RESTORE)
                          && !w_stk_stat.empty && !w_rows_we;
    end

    lrt_undo_stack #(
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_stk_cmd),
        .i_push_data (r_cursor),
        .o_pop_data  (w_stk_data),
        .o_stat      (w_stk_stat)
    );

    // The cursor on the head sentinel means the table is empty and reads 0.
    assign w_cur_m1   = 32'(r_cursor) - 32'd1;
    assign w_cur_row  = (r_cursor == '0) ? '0 : w_cur_m1[ROW_W-1:0];
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_rows      <= RW'(RESET_ROWS);
            r_start     <= '0;
            r_cursor    <= AW'(1);
            r_out_valid <= 1'b0;
        end else begin
            // The result state loads its own valid, so the drain of a taken
            // result is left to it there.
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            if (w_rows_we) begin
                // A row count write rebuilds the whole list from scratch.
                r_state  <= S_CLEAR;
                r_clr    <= '0;
                r_rows   <= RW'(w_new_rows);
                r_cursor <= AW'(w_new_cursor);
            end else begin
                case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + AW'(1);
                        if (r_clr == w_tail) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (w_in_acc) begin
                            r_func  <= i_func;
                            r_steps <= i_steps;
                            r_query <= i_query_row;
                            r_cnt   <= '0;
                            r_err   <= 1'b0;
                            r_state <= S_START;
                        end
                    end
                    S_START: begin
                        case (r_func)
                            FUNC_UP, FUNC_DOWN: begin
                                if ((r_cursor == '0) || (r_steps == '0)) begin
                                    r_state <= S_QRY;
                                end else begin
                                    r_state <= S_MOVE;
                                end
                            end
                            FUNC_DELETE: begin
                                if ((r_cursor == '0) || w_stk_stat.full) begin
                                    r_err   <= 1'b1;
                                    r_state <= S_QRY;
                                end else begin
                                    r_state <= S_DEL;
                                end
                            end
                            FUNC_RESTORE: begin
                                if (w_stk_stat.empty) begin
                                    r_err   <= 1'b1;
                                    r_state <= S_QRY;
                                end else begin
                                    r_state <= S_RST_A;
                                end
                            end
                            default: begin
                                r_state <= S_QRY;
                            end
                        endcase
                    end
                    S_MOVE: begin
                        if (w_step_go) begin
                            r_cursor <= w_link;
                            r_cnt    <= r_cnt + STEP_W'(1);
                        end else begin
                            r_state <= S_QRY;
                        end
                    end
                    S_DEL: begin
                        // Prefer the following row; fall back to the previous
                        // one, which is the head sentinel when the table empties.
                        r_cursor <= (r_next_rd == w_tail) ? r_prev_rd : r_next_rd;
                        r_state  <= S_QRY;
                    end
                    S_RST_A: begin
                        r_rest  <= w_stk_data;
                        r_state <= S_RST_B;
                    end
                    S_RST_B: begin
                        if (r_cursor == '0) begin
                            r_cursor <= r_rest;
                        end
                        r_state <= S_QRY;
                    end
                    S_QRY: begin
                        r_qok   <= (32'(r_query) < 32'(r_rows));
                        r_state <= S_OUT;
                    end
                    S_OUT: begin
                        if (w_out_free) begin
                            r_out_valid   <= 1'b1;
                            r_out_cursor  <= w_cur_row;
                            r_out_present <= r_qok && r_pres_rd;
                            r_out_err     <= r_err;
                            r_state       <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
            if (w_cfg_we && (i_cfg_index == CFG_START_ROW)) begin
                r_start <= i_cfg_data[ROW_W-1:0];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cursor_row  = r_out_cursor;
    assign o_row_present = r_out_present;
    assign o_error       = r_out_err;

    a_cursor_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cursor != w_tail) && (r_cursor <= AW'(r_rows)))
        else $error("cursor outside the table while idle");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside the result state");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |-> (r_cnt <= r_steps))
        else $error("link walk ran past its step count");

    a_restore_empty_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) && (r_func == FUNC_RESTORE) && w_stk_stat.empty
        && !w_rows_we |=> r_err)
        else $error("restore on an empty stack did not flag an error");

endmodule

@@ verif/lrt_cursor_checker.sv @@
// Checker that predicts and compares every result transaction of the linked row table.
`timescale 1ns / 100ps

module lrt_cursor_checker
    import lrt_pkg::*;
#(
    parameter int MAX_ROWS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [STEP_W-1:0] i_steps,
    input  logic [ROW_W-1:0]  i_query_row,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [ROW_W-1:0]  i_cursor_row,
    input  logic              i_row_present,
    input  logic              i_error,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output int unsigned       o_fail_count,
    output int unsigned       o_pending
);

    localparam int ENTRIES = MAX_ROWS + 2;

    typedef struct packed {
        logic [ROW_W-1:0] cursor_row;
        logic             row_present;
        logic             error;
    } t_row_report;

    // Own copy of the table: entry 0 is the head, entry rows+1 the tail.
    logic [CNT_W-1:0] link_prev    [ENTRIES];
    logic [CNT_W-1:0] link_next    [ENTRIES];
    logic             row_live     [ENTRIES];
    logic [CNT_W-1:0] deleted_rows [MAX_ROWS];
    int unsigned      deleted_depth;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] cfg_row_count;
    logic [ROW_W-1:0] cfg_start_row;
    int unsigned      rows_in_use;

    t_row_report expected_reports [$];
    int unsigned fail_count;
    int unsigned pending_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic void rebuild_table();
        int unsigned n;
        int unsigned s;
        n = cfg_row_count;
        if (n < 1) n = 1;
        if (n > MAX_ROWS) n = MAX_ROWS;
        rows_in_use = n;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i < n + 2) begin
                link_prev[i] = (i == 0) ? '0 : CNT_W'(i - 1);
                link_next[i] = (i == n + 1) ? CNT_W'(i) : CNT_W'(i + 1);
                row_live[i]  = 1'b1;
            end else begin
                link_prev[i] = '0;
                link_next[i] = '0;
                row_live[i]  = 1'b0;
            end
        end
        deleted_depth = 0;
        s = cfg_start_row;
        if (s > n - 1) s = n - 1;
        cur = CNT_W'(s + 1);
    endfunction

    function automatic t_row_report apply_command(input logic [FUNC_W-1:0] f,
                                                  input logic [STEP_W-1:0] st,
                                                  input logic [ROW_W-1:0]  q);
        t_row_report      r;
        int unsigned      tail;
        logic             table_empty;
        logic             err;
        logic [CNT_W-1:0] k;
        logic [CNT_W-1:0] p;
        logic [CNT_W-1:0] nx;
        logic [CNT_W-1:0] shown;
        tail        = rows_in_use + 1;
        table_empty = (cur == 0);
        err         = 1'b0;
        case (f)
            FUNC_UP: begin
                if (!table_empty) begin
                    for (int j = 0; j < st && link_prev[cur] != 0; j++) cur = link_prev[cur];
                end
            end
            FUNC_DOWN: begin
                if (!table_empty) begin
                    for (int j = 0; j < st && link_next[cur] != tail; j++) cur = link_next[cur];
                end
            end
            FUNC_DELETE: begin
                if (table_empty || deleted_depth >= MAX_ROWS) begin
                    err = 1'b1;
                end else begin
                    k  = cur;
                    p  = link_prev[k];
                    nx = link_next[k];
                    link_next[p]  = nx;
                    link_prev[nx] = p;
                    row_live[k]   = 1'b0;
                    deleted_rows[deleted_depth] = k;
                    deleted_depth++;
                    cur = (nx == tail) ? p : nx;
                end
            end
            FUNC_RESTORE: begin
                if (deleted_depth == 0) begin
                    err = 1'b1;
                end else begin
                    deleted_depth--;
                    k = deleted_rows[deleted_depth];
                    link_next[link_prev[k]] = k;
                    link_prev[link_next[k]] = k;
                    row_live[k] = 1'b1;
                    if (cur == 0) cur = k;
                end
            end
            default: begin
            end
        endcase
        shown          = (cur == 0) ? '0 : cur - 1'b1;
        r.cursor_row   = shown[ROW_W-1:0];
        r.row_present  = (q < rows_in_use) ? row_live[q + 11'd1] : 1'b0;
        r.error        = err;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_row_report want;
        if (!i_rst_n) begin
            cfg_row_count = CNT_W'(1024);
            cfg_start_row = '0;
            rebuild_table();
            expected_reports.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1) begin
                if (i_cfg_index == CFG_ROW_COUNT) begin
                    cfg_row_count = i_cfg_data;
                    rebuild_table();
                end else begin
                    cfg_start_row = i_cfg_data[ROW_W-1:0];
                end
            end
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result with nothing expected: cursor %0d present %0d error %0d",
                             $time, i_cursor_row, i_row_present, i_error);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_cursor_row !== want.cursor_row) begin
                        $display("%0t: cursor_row expected %0d actual %0d",
                                 $time, want.cursor_row, i_cursor_row);
                        fail_count++;
                    end
                    if (i_row_present !== want.row_present) begin
                        $display("%0t: row_present expected %0d actual %0d",
                                 $time, want.row_present, i_row_present);
                        fail_count++;
                    end
                    if (i_error !== want.error) begin
                        $display("%0t: error expected %0d actual %0d",
                                 $time, want.error, i_error);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                expected_reports.push_back(apply_command(i_func, i_steps, i_query_row));
            end
        end
        pending_count = expected_reports.size();
    end

endmodule

@@ verif/linked_row_table_with_undo_tb.sv @@
// Top level of the linked row table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module linked_row_table_with_undo_tb;
    import lrt_pkg::*;

    localparam int MAX_ROWS = 1024;
    // Longest stretch without any transaction on any channel. The slowest
    // honest stretch is a clearing pass or a full-length move, plus the long
    // receiver hold-off; this is several times that.
    localparam int IDLE_LIMIT = 20000;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 75;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [FUNC_W-1:0] i_func      = '0;
    logic [STEP_W-1:0] i_steps     = '0;
    logic [ROW_W-1:0]  i_query_row = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [ROW_W-1:0]  o_cursor_row;
    logic              o_row_present;
    logic              o_error;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = 1'b0;
    logic [CNT_W-1:0]  i_cfg_data  = '0;

    int unsigned fail_count;
    int unsigned pending;

    // Set once by the stimulus; the receiver then holds off on its own count.
    logic        hold_request = 1'b0;
    // Sender burst bookkeeping and the row count the queries are aimed at.
    int unsigned burst_left   = 0;
    int unsigned rows_aimed   = 1024;

    linked_row_table_with_undo #(
        .MAX_ROWS (MAX_ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_steps       (i_steps),
        .i_query_row   (i_query_row),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cursor_row  (o_cursor_row),
        .o_row_present (o_row_present),
        .o_error       (o_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    lrt_cursor_checker #(
        .MAX_ROWS (MAX_ROWS)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_steps       (i_steps),
        .i_query_row   (i_query_row),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_cursor_row  (o_cursor_row),
        .i_row_present (o_row_present),
        .i_error       (o_error),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The watchdog counts cycles in which no channel completes a transaction.
    always @(posedge i_clk) begin
        int unsigned idle_cycles;
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                     (o_out_valid === 1'b1 && i_out_stall === 1'b0) ||
                     (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // The receiver stalls in stretches of random length, each with its own
    // stall density, so that some stretches never stall and others nearly
    // always do. When the stimulus asks for it, it holds off completely once,
    // so that the block fills and stalls its input.
    initial begin : result_sink
        int unsigned mode_left = 0;
        int unsigned stall_pct = 0;
        int unsigned hold_left = 0;
        bit          hold_used = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_used) begin
                hold_used = 1'b1;
                hold_left = 400;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(10, 80);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Offers one command transaction. Called at a falling edge; returns at
    // the falling edge after acceptance with valid still high, so that the
    // next transaction can follow back to back. The sender works in bursts
    // with random gaps between them, and some bursts follow with no gap.
    task automatic offer_item(input logic [FUNC_W-1:0] f, input int unsigned st,
                              input int unsigned q);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_func      = f;
        i_steps     = st[STEP_W-1:0];
        i_query_row = q[ROW_W-1:0];
        i_in_valid  = 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input logic idx, input int unsigned value);
        i_cfg_index = idx;
        i_cfg_data  = value[CNT_W-1:0];
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Starts a new table: the start row is written first so that the
    // rebuild triggered by the row count write picks it up.
    task automatic load_table(input int unsigned start, input int unsigned count);
        drain_results();
        write_register(CFG_START_ROW, start);
        write_register(CFG_ROW_COUNT, count);
        rows_aimed = (count == 0) ? 1 : (count > MAX_ROWS) ? MAX_ROWS : count;
    endtask

    // One random command. Deletes are weighted by the caller so that some
    // phases empty the table and walk deep into the undo stack. Moves are
    // mostly short, with the odd full-range count; queries mostly land on
    // rows in use, with some anywhere in the field's range.
    task automatic offer_random(input int unsigned delete_pct);
        int unsigned pick;
        int unsigned st;
        int unsigned q;
        logic [FUNC_W-1:0] f;
        pick = $urandom_range(0, 99);
        if (pick < delete_pct) begin
            f = FUNC_DELETE;
        end else if (pick < delete_pct + 20) begin
            f = FUNC_RESTORE;
        end else if (pick[0]) begin
            f = FUNC_UP;
        end else begin
            f = FUNC_DOWN;
        end
        st = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 7);
        q  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                          : $urandom_range(0, rows_aimed - 1);
        offer_item(f, st, q);
    endtask

    initial begin : stimulus
        int unsigned rows;
        int unsigned start;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default table after reset: all 1024 rows, cursor on row 0.
        offer_item(FUNC_UP, 0, 0);
        offer_item(FUNC_UP, 1023, 1023);
        offer_item(FUNC_DOWN, 1023, 1023);
        offer_item(FUNC_DOWN, 5, 1022);
        // Deleting the last row sends the cursor back one row.
        offer_item(FUNC_DELETE, 0, 1023);
        offer_item(FUNC_RESTORE, 0, 1023);
        // Undo stack now empty, so the restore is refused.
        offer_item(FUNC_RESTORE, 0, 1023);
        offer_item(FUNC_DELETE, 0, 1022);

        // Start row beyond the table saturates; bit 10 of the data is dropped.
        load_table(2047, 5);
        offer_item(FUNC_DELETE, 0, 4);
        offer_item(FUNC_UP, 1023, 0);
        // Empty the table completely, then poke at it.
        repeat (4) offer_item(FUNC_DELETE, 1, 0);
        offer_item(FUNC_UP, 3, 1023);
        offer_item(FUNC_DELETE, 0, 2);
        // Restoring into an empty table puts the cursor on the restored row.
        offer_item(FUNC_RESTORE, 0, 3);

        // A row count of zero is taken as one row.
        load_table(0, 0);
        offer_item(FUNC_DELETE, 0, 0);
        offer_item(FUNC_DOWN, 1, 0);
        offer_item(FUNC_RESTORE, 0, 0);
        offer_item(FUNC_RESTORE, 0, 1);

        // An oversized row count clamps to the full table.
        load_table(1023, 2047);
        offer_item(FUNC_UP, 1023, 512);
        offer_item(FUNC_DOWN, 300, 300);

        // Random phases, mostly small tables so that deletes reach the ends
        // and the empty state often; one full table and one two-row table.
        for (int p = 0; p < PHASES; p++) begin
            if (p == 3) begin
                rows  = MAX_ROWS;
                start = $urandom_range(0, 1023);
            end else if (p == 7) begin
                rows  = 2;
                start = 1023;
            end else begin
                rows  = $urandom_range(1, 48);
                start = $urandom_range(0, 63);
            end
            load_table(start, rows);
            if (p == 5) hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                offer_random((p % 2 == 1) ? 45 : 20);
            end
        end

        drain_results();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
